/* hw/rtl/sccd_pkg.sv */
// Package for the sector cache directory: field widths, result and request codes,
// and the microprogram that sequences the directory datapath.
// No dependencies; imported by sector_cache_clock_directory_top.
`timescale 1ns / 1ps

package sccd_pkg;

    localparam int DEF_SLOTS        = 64;
    localparam int DEF_SECTOR_BYTES = 512;

    localparam int FUNC_W   = 3;
    localparam int SECTOR_W = 32;
    localparam int OFFSET_W = 9;
    localparam int LENGTH_W = 10;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int PERIOD_W = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    typedef enum logic [FUNC_W-1:0] {
        F_READ      = 3'd0,
        F_WRITE     = 3'd1,
        F_READAHEAD = 3'd2,
        F_TICK      = 3'd3,
        F_FLUSH     = 3'd4
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        K_GRANT = 3'd0,
        K_FILL  = 3'd1,
        K_WB    = 3'd2,
        K_ERR   = 3'd3,
        K_DONE  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_TICK,
        C_IS_FLUSH,
        C_IS_BAD,
        C_HIT,
        C_SLOT_INVALID,
        C_NOT_ACCESSED,
        C_NOT_DIRTY,
        C_NO_FILL,
        C_READAHEAD,
        C_TICK_DUE,
        C_NONE_DIRTY,
        C_NO_MORE_DIRTY
    } cond_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_IDX_HIT,
        A_IDX_ZERO,
        A_IDX_INC,
        A_CLR_ACC_INC,
        A_INSTALL,
        A_TOUCH,
        A_TICK,
        A_CLEAN
    } act_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_WB,
        E_WB_SCAN,
        E_FILL,
        E_GRANT,
        E_DONE_SLOT,
        E_DONE_ZERO,
        E_ERR
    } emit_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        cond_t cond;
        upc_t  target;
        act_t  act;
        emit_t emit;
        logic  last;
    } uword_t;

    localparam upc_t U_IDLE       = 5'd0;
    localparam upc_t U_DISP_TICK  = 5'd1;
    localparam upc_t U_DISP_FLUSH = 5'd2;
    localparam upc_t U_DISP_BAD   = 5'd3;
    localparam upc_t U_LOOKUP     = 5'd4;
    localparam upc_t U_EV_TEST    = 5'd5;
    localparam upc_t U_EV_ACC     = 5'd6;
    localparam upc_t U_EV_SKIP    = 5'd7;
    localparam upc_t U_EV_DIRTY   = 5'd8;
    localparam upc_t U_EV_WB      = 5'd9;
    localparam upc_t U_INSTALL    = 5'd10;
    localparam upc_t U_FILL_TEST  = 5'd11;
    localparam upc_t U_FILL       = 5'd12;
    localparam upc_t U_FINISH     = 5'd13;
    localparam upc_t U_GRANT      = 5'd14;
    localparam upc_t U_RA_DONE    = 5'd15;
    localparam upc_t U_ERROR      = 5'd16;
    localparam upc_t U_TICK       = 5'd17;
    localparam upc_t U_DONE_ZERO  = 5'd18;
    localparam upc_t U_WD_START   = 5'd19;
    localparam upc_t U_WD_TEST    = 5'd20;
    localparam upc_t U_WD_EMIT    = 5'd21;
    localparam upc_t U_WD_NEXT    = 5'd22;

    // A taken condition jumps to target; otherwise the step counter advances.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        unique case (pc)
            U_IDLE:       w = '{C_NO_INPUT,      U_IDLE,       A_ACCEPT,      E_NONE,      1'b0};
            U_DISP_TICK:  w = '{C_IS_TICK,       U_TICK,       A_NONE,        E_NONE,      1'b0};
            U_DISP_FLUSH: w = '{C_IS_FLUSH,      U_WD_START,   A_NONE,        E_NONE,      1'b0};
            U_DISP_BAD:   w = '{C_IS_BAD,        U_ERROR,      A_NONE,        E_NONE,      1'b0};
            U_LOOKUP:     w = '{C_HIT,           U_FINISH,     A_IDX_HIT,     E_NONE,      1'b0};
            U_EV_TEST:    w = '{C_SLOT_INVALID,  U_INSTALL,    A_NONE,        E_NONE,      1'b0};
            U_EV_ACC:     w = '{C_NOT_ACCESSED,  U_EV_DIRTY,   A_NONE,        E_NONE,      1'b0};
            U_EV_SKIP:    w = '{C_ALWAYS,        U_EV_TEST,    A_CLR_ACC_INC, E_NONE,      1'b0};
            U_EV_DIRTY:   w = '{C_NOT_DIRTY,     U_INSTALL,    A_NONE,        E_NONE,      1'b0};
            U_EV_WB:      w = '{C_NEXT,          U_IDLE,       A_NONE,        E_WB,        1'b0};
            U_INSTALL:    w = '{C_NEXT,          U_IDLE,       A_INSTALL,     E_NONE,      1'b0};
            U_FILL_TEST:  w = '{C_NO_FILL,       U_FINISH,     A_NONE,        E_NONE,      1'b0};
            U_FILL:       w = '{C_NEXT,          U_IDLE,       A_NONE,        E_FILL,      1'b0};
            U_FINISH:     w = '{C_READAHEAD,     U_RA_DONE,    A_NONE,        E_NONE,      1'b0};
            U_GRANT:      w = '{C_ALWAYS,        U_IDLE,       A_TOUCH,       E_GRANT,     1'b1};
            U_RA_DONE:    w = '{C_ALWAYS,        U_IDLE,       A_NONE,        E_DONE_SLOT, 1'b1};
            U_ERROR:      w = '{C_ALWAYS,        U_IDLE,       A_NONE,        E_ERR,       1'b1};
            U_TICK:       w = '{C_TICK_DUE,      U_WD_START,   A_TICK,        E_NONE,      1'b0};
            U_DONE_ZERO:  w = '{C_ALWAYS,        U_IDLE,       A_NONE,        E_DONE_ZERO, 1'b1};
            U_WD_START:   w = '{C_NONE_DIRTY,    U_DONE_ZERO,  A_IDX_ZERO,    E_NONE,      1'b0};
            U_WD_TEST:    w = '{C_NOT_DIRTY,     U_WD_NEXT,    A_NONE,        E_NONE,      1'b0};
            U_WD_EMIT:    w = '{C_NO_MORE_DIRTY, U_IDLE,       A_CLEAN,       E_WB_SCAN,   1'b0};
            U_WD_NEXT:    w = '{C_ALWAYS,        U_WD_TEST,    A_IDX_INC,     E_NONE,      1'b0};
            default:      w = '{C_ALWAYS,        U_IDLE,       A_NONE,        E_NONE,      1'b0};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/sector_cache_clock_directory_top.sv */
// Sector cache directory with clock (second-chance) replacement, run by a microprogram.
// Depends on sccd_pkg for widths, codes and the control store.
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------
//   request  | in_valid/in_stall  | func, sector, offset, length
//   result   | out_valid/out_stall| kind, slot, sector_out, last
//   config   | cfg_we             | cfg_data (write-behind period)
//
// One request is worked at a time; a read or write hit passes dispatch, lookup and
// finish before its grant. The victim scan passes a slot by test, accessed and skip;
// the write-behind and flush scans by test and next if clean, test, emit and next if
// dirty. The sequencer runs one step per cycle; a stalled result holds it at its
// emitting step. Reset clears all slot state at once; no clearing pass is needed.
`timescale 1ns / 1ps

module sector_cache_clock_directory_top #(
    parameter int SLOTS        = sccd_pkg::DEF_SLOTS,
    parameter int SECTOR_BYTES = sccd_pkg::DEF_SECTOR_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sccd_pkg::FUNC_W-1:0]   func,
    input  logic [sccd_pkg::SECTOR_W-1:0] sector,
    input  logic [sccd_pkg::OFFSET_W-1:0] offset,
    input  logic [sccd_pkg::LENGTH_W-1:0] length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sccd_pkg::KIND_W-1:0]   kind,
    output logic [sccd_pkg::SLOT_W-1:0]   slot,
    output logic [sccd_pkg::SECTOR_W-1:0] sector_out,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [sccd_pkg::PERIOD_W-1:0] cfg_data
);
    import sccd_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int SB_W    = $clog2(SECTOR_BYTES + 1);
    localparam int RANGE_W = (SB_W > LENGTH_W + 1) ? SB_W : LENGTH_W + 1;

    // Control state.
    upc_t                pc_reg, pc_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    dirty_reg, dirty_next;
    logic [SLOTS-1:0]    acc_reg, acc_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [FUNC_W-1:0]   func_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [OFFSET_W-1:0] ofs_reg;
    logic [LENGTH_W-1:0] len_reg;
    logic [SLOTS-1:0]    hit_vec_reg, hit_vec_next;
    logic [SECTOR_W-1:0] tag_rd_reg;
    logic [SECTOR_W-1:0] tag_cam_reg [SLOTS];
    logic [SECTOR_W-1:0] tag_mem [SLOTS];
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SECTOR_W-1:0] sector_out_reg, sector_out_next;
    logic                last_reg, last_next;

    uword_t              uw;
    logic                out_free;
    logic                step_go;
    logic                take;
    logic                accept_load;
    logic                tag_we;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    idx_inc;
    logic                more_dirty;
    logic                bad_req;
    logic [RANGE_W-1:0]  range_end;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W-1:0] tick_inc;
    logic                tick_due;

    assign uw       = ucode(pc_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign step_go  = (uw.emit == E_NONE) || out_free;
    assign in_stall = (pc_reg != U_IDLE);

    assign accept_load = (pc_reg == U_IDLE) && in_valid;
    assign tag_we      = step_go && (uw.act == A_INSTALL);

    assign idx_inc    = (idx_reg == IDX_W'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign range_end  = RANGE_W'(ofs_reg) + RANGE_W'(len_reg);
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign tick_inc   = tick_reg + 1'b1;
    assign tick_due   = (tick_inc >= period_eff);

    assign bad_req = !(func_reg == F_READ || func_reg == F_WRITE || func_reg == F_READAHEAD)
                     || (sec_reg == '1)
                     || ((func_reg != F_READAHEAD)
                         && (range_end > RANGE_W'(SECTOR_BYTES)));

    always_comb
    begin
        hit_idx    = '0;
        more_dirty = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            hit_vec_next[j] = valid_reg[j] && (tag_cam_reg[j] == sec_reg);
            if (hit_vec_reg[j])
                hit_idx = hit_idx | IDX_W'(j);
            if (dirty_reg[j] && (IDX_W'(j) > idx_reg))
                more_dirty = 1'b1;
        end
    end

    assign hit = |hit_vec_reg;

    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:          take = 1'b0;
            C_ALWAYS:        take = 1'b1;
            C_NO_INPUT:      take = !in_valid;
            C_IS_TICK:       take = (func_reg == F_TICK);
            C_IS_FLUSH:      take = (func_reg == F_FLUSH);
            C_IS_BAD:        take = bad_req;
            C_HIT:           take = hit;
            C_SLOT_INVALID:  take = !valid_reg[idx_reg];
            C_NOT_ACCESSED:  take = !acc_reg[idx_reg];
            C_NOT_DIRTY:     take = !dirty_reg[idx_reg];
            C_NO_FILL:       take = (func_reg == F_WRITE) && (ofs_reg == '0);
            C_READAHEAD:     take = (func_reg == F_READAHEAD);
            C_TICK_DUE:      take = tick_due;
            C_NONE_DIRTY:    take = (dirty_reg == '0);
            C_NO_MORE_DIRTY: take = !more_dirty;
            default:         take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next     = pc_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        acc_next    = acc_reg;
        tick_next   = tick_reg;
        period_next = cfg_we ? cfg_data : period_reg;

        if (step_go)
        begin
            pc_next = take ? uw.target : pc_reg + 1'b1;
            unique case (uw.act) inside
                A_NONE, A_ACCEPT:
                begin
                end
                A_IDX_HIT:  idx_next = hit ? hit_idx : '0;
                A_IDX_ZERO: idx_next = '0;
                A_IDX_INC:  idx_next = idx_inc;
                A_CLR_ACC_INC:
                begin
                    acc_next[idx_reg] = 1'b0;
                    idx_next          = idx_inc;
                end
                A_INSTALL:
                begin
                    valid_next[idx_reg] = 1'b1;
                    dirty_next[idx_reg] = 1'b0;
                    acc_next[idx_reg]   = 1'b0;
                end
                A_TOUCH:
                begin
                    acc_next[idx_reg] = 1'b1;
                    if (func_reg == F_WRITE)
                        dirty_next[idx_reg] = 1'b1;
                end
                A_TICK:     tick_next = tick_due ? '0 : tick_inc;
                A_CLEAN:
                begin
                    if (func_reg == F_TICK)
                        dirty_next[idx_reg] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        sector_out_next = sector_out_reg;
        last_next       = last_reg;
        out_valid_next  = out_stall ? out_valid_reg : 1'b0;

        if (uw.emit != E_NONE && out_free)
        begin
            out_valid_next  = 1'b1;
            slot_next       = SLOT_W'(idx_reg);
            sector_out_next = sec_reg;
            last_next       = uw.last;
            unique case (uw.emit)
                E_WB:
                begin
                    kind_next       = K_WB;
                    sector_out_next = tag_rd_reg;
                end
                E_WB_SCAN:
                begin
                    kind_next       = K_WB;
                    sector_out_next = tag_rd_reg;
                    last_next       = !more_dirty;
                end
                E_FILL:      kind_next = K_FILL;
                E_GRANT:     kind_next = K_GRANT;
                E_DONE_SLOT: kind_next = K_DONE;
                E_DONE_ZERO:
                begin
                    kind_next       = K_DONE;
                    slot_next       = '0;
                    sector_out_next = '0;
                end
                E_ERR:
                begin
                    kind_next = K_ERR;
                    slot_next = '0;
                end
                default:     kind_next = K_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= U_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            acc_reg       <= '0;
            tick_reg      <= '0;
            period_reg    <= PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            acc_reg       <= acc_next;
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_load)
        begin
            func_reg <= func;
            sec_reg  <= sector;
            ofs_reg  <= offset;
            len_reg  <= length;
        end
        hit_vec_reg    <= hit_vec_next;
        kind_reg       <= kind_next;
        slot_reg       <= slot_next;
        sector_out_reg <= sector_out_next;
        last_reg       <= last_next;
        if (tag_we)
            tag_cam_reg[idx_reg] <= sec_reg;
    end

    // Tag store for write-back words, read at the current slot every cycle.
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[idx_reg] <= sec_reg;
        tag_rd_reg <= tag_mem[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign sector_out = sector_out_reg;
    assign last       = last_reg;

endmodule
